@@ rtl/tcpq_pkg.sv @@
// Shared types, codes and defaults of the two-class priority queue.
package tcpq_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int TAG_WIDTH_DEF = 16;
    localparam int TAG_BITS      = 16;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_POP_EMPTY  = 2'd1,
        STAT_PUSH_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_HIGH = 2'd1,
        SEL_LOW  = 2'd2
    } sel_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LOAD = 1'b1
    } state_t;

    typedef struct packed {
        logic    load;
        status_t status;
        sel_t    front_sel;
        sel_t    back_sel;
    } res_t;

endpackage

@@ rtl/two_class_priority_queue.sv @@
// Top level of the two-class priority queue: tag memories, control and result register.
// Each word on s_ pushes a tag (high class goes behind all queued high tags, low class goes
// to the back) or pops the front tag, and yields exactly one word on m_ that describes the
// queue after the operation. No new word is taken until the last result loads: the accept
// cycle updates the ring pointers and writes the tag memory, and the next cycle waits on
// the registered read of the front and back entries before the result register loads.
// s_ready stays high while a finished result waits on m_, so one more word is taken before
// the output stalls the queue. Reset clears pointers, counts, state and m_valid; tag memories need no clearing.
module two_class_priority_queue import tcpq_pkg::*; #(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int TAG_WIDTH = TAG_WIDTH_DEF,
    parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [TAG_BITS-1:0] s_item_tag,
    input  logic                s_is_high,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TAG_BITS-1:0] m_front_tag,
    output logic                m_front_is_high,
    output logic [TAG_BITS-1:0] m_back_tag,
    output logic [CNT_W-1:0]    m_total_count,
    output logic [CNT_W-1:0]    m_high_count,
    output logic [CNT_W-1:0]    m_low_count,
    output logic                m_is_empty,
    output logic [1:0]          m_status
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int SW    = (TAG_WIDTH < TAG_BITS) ? TAG_WIDTH : TAG_BITS;

    logic             out_free;
    logic             high_we, low_we, rd_en;
    logic [PTR_W-1:0] high_wr_addr, low_wr_addr;
    logic [PTR_W-1:0] high_rd_front, high_rd_back, low_rd_front, low_rd_back;
    logic [SW-1:0]    high_front_data, high_back_data, low_front_data, low_back_data;
    logic [CNT_W-1:0] high_count, low_count, total;
    res_t             res;

    logic [TAG_BITS-1:0] front_tag, back_tag;

    logic                m_valid_reg;
    logic [TAG_BITS-1:0] front_tag_reg, back_tag_reg;
    logic                front_is_high_reg;
    logic [CNT_W-1:0]    total_reg, high_count_reg, low_count_reg;
    logic                is_empty_reg;
    status_t             status_reg;

    assign out_free = !m_valid_reg || m_ready;

    tcpq_ctrl #(
        .CAPACITY (CAPACITY),
        .PTR_W    (PTR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_op          (s_op),
        .s_is_high     (s_is_high),
        .s_ready       (s_ready),
        .out_free      (out_free),
        .high_we       (high_we),
        .low_we        (low_we),
        .high_wr_addr  (high_wr_addr),
        .low_wr_addr   (low_wr_addr),
        .rd_en         (rd_en),
        .high_rd_front (high_rd_front),
        .high_rd_back  (high_rd_back),
        .low_rd_front  (low_rd_front),
        .low_rd_back   (low_rd_back),
        .high_count    (high_count),
        .low_count     (low_count),
        .res           (res)
    );

    tcpq_store #(
        .DEPTH (CAPACITY),
        .WIDTH (SW),
        .AW    (PTR_W)
    ) u_high_store (
        .aclk      (aclk),
        .wr_en     (high_we),
        .wr_addr   (high_wr_addr),
        .wr_data   (s_item_tag[SW-1:0]),
        .rd_en     (rd_en),
        .rd_addr_a (high_rd_front),
        .rd_addr_b (high_rd_back),
        .rd_data_a (high_front_data),
        .rd_data_b (high_back_data)
    );

    tcpq_store #(
        .DEPTH (CAPACITY),
        .WIDTH (SW),
        .AW    (PTR_W)
    ) u_low_store (
        .aclk      (aclk),
        .wr_en     (low_we),
        .wr_addr   (low_wr_addr),
        .wr_data   (s_item_tag[SW-1:0]),
        .rd_en     (rd_en),
        .rd_addr_a (low_rd_front),
        .rd_addr_b (low_rd_back),
        .rd_data_a (low_front_data),
        .rd_data_b (low_back_data)
    );

    assign total = high_count + low_count;

    always_comb begin
        case (res.front_sel)
            SEL_HIGH: front_tag = TAG_BITS'(high_front_data);
            SEL_LOW:  front_tag = TAG_BITS'(low_front_data);
            default:  front_tag = '0;
        endcase
        case (res.back_sel)
            SEL_HIGH: back_tag = TAG_BITS'(high_back_data);
            SEL_LOW:  back_tag = TAG_BITS'(low_back_data);
            default:  back_tag = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.load) begin
            front_tag_reg     <= front_tag;
            front_is_high_reg <= (res.front_sel == SEL_HIGH);
            back_tag_reg      <= back_tag;
            total_reg         <= total;
            high_count_reg    <= high_count;
            low_count_reg     <= low_count;
            is_empty_reg      <= (total == '0);
            status_reg        <= res.status;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_front_tag     = front_tag_reg;
    assign m_front_is_high = front_is_high_reg;
    assign m_back_tag      = back_tag_reg;
    assign m_total_count   = total_reg;
    assign m_high_count    = high_count_reg;
    assign m_low_count     = low_count_reg;
    assign m_is_empty      = is_empty_reg;
    assign m_status        = status_reg;

endmodule

@@ rtl/tcpq_store.sv @@
// Tag memory of one class: one write port, two registered read ports with write forwarding.
module tcpq_store import tcpq_pkg::*; #(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int WIDTH = TAG_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
            rd_data_b_reg <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

@@ rtl/tcpq_ctrl.sv @@
// Pointer, count and sequencing control of the two-class priority queue.
module tcpq_ctrl import tcpq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int PTR_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_op,
    input  logic             s_is_high,
    output logic             s_ready,
    input  logic             out_free,
    output logic             high_we,
    output logic             low_we,
    output logic [PTR_W-1:0] high_wr_addr,
    output logic [PTR_W-1:0] low_wr_addr,
    output logic             rd_en,
    output logic [PTR_W-1:0] high_rd_front,
    output logic [PTR_W-1:0] high_rd_back,
    output logic [PTR_W-1:0] low_rd_front,
    output logic [PTR_W-1:0] low_rd_back,
    output logic [CNT_W-1:0] high_count,
    output logic [CNT_W-1:0] low_count,
    output res_t             res
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] high_head_reg, high_head_next;
    logic [PTR_W-1:0] high_tail_reg, high_tail_next;
    logic [PTR_W-1:0] low_head_reg, low_head_next;
    logic [PTR_W-1:0] low_tail_reg, low_tail_next;
    logic [CNT_W-1:0] high_items_reg, high_items_next;
    logic [CNT_W-1:0] low_items_reg, low_items_next;
    status_t          status_reg, status_next;
    sel_t             front_sel_reg, front_sel_next;
    sel_t             back_sel_reg, back_sel_next;
    logic             accept;
    logic [CNT_W-1:0] total;

    assign accept = s_valid && s_ready;
    assign total  = high_items_reg + low_items_reg;

    always_comb begin
        high_head_next  = high_head_reg;
        high_tail_next  = high_tail_reg;
        low_head_next   = low_head_reg;
        low_tail_next   = low_tail_reg;
        high_items_next = high_items_reg;
        low_items_next  = low_items_reg;
        status_next     = STAT_OK;
        high_we         = 1'b0;
        low_we          = 1'b0;
        if (accept) begin
            if (s_op == OP_PUSH) begin
                if (total == CNT_FULL) begin
                    status_next = STAT_PUSH_FULL;
                end else if (s_is_high) begin
                    high_we         = 1'b1;
                    high_tail_next  = (high_tail_reg == PTR_LAST) ? '0 : high_tail_reg + 1'b1;
                    high_items_next = high_items_reg + 1'b1;
                end else begin
                    low_we         = 1'b1;
                    low_tail_next  = (low_tail_reg == PTR_LAST) ? '0 : low_tail_reg + 1'b1;
                    low_items_next = low_items_reg + 1'b1;
                end
            end else begin
                if (total == '0) begin
                    status_next = STAT_POP_EMPTY;
                end else if (high_items_reg != '0) begin
                    high_head_next  = (high_head_reg == PTR_LAST) ? '0 : high_head_reg + 1'b1;
                    high_items_next = high_items_reg - 1'b1;
                end else begin
                    low_head_next  = (low_head_reg == PTR_LAST) ? '0 : low_head_reg + 1'b1;
                    low_items_next = low_items_reg - 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (high_items_next != '0) begin
            front_sel_next = SEL_HIGH;
        end else if (low_items_next != '0) begin
            front_sel_next = SEL_LOW;
        end else begin
            front_sel_next = SEL_NONE;
        end
        if (low_items_next != '0) begin
            back_sel_next = SEL_LOW;
        end else if (high_items_next != '0) begin
            back_sel_next = SEL_HIGH;
        end else begin
            back_sel_next = SEL_NONE;
        end
    end

    assign high_wr_addr  = high_tail_reg;
    assign low_wr_addr   = low_tail_reg;
    assign rd_en         = accept;
    assign high_rd_front = high_head_next;
    assign low_rd_front  = low_head_next;
    assign high_rd_back  = (high_tail_next == '0) ? PTR_LAST : high_tail_next - 1'b1;
    assign low_rd_back   = (low_tail_next == '0) ? PTR_LAST : low_tail_next - 1'b1;
    assign high_count    = high_items_reg;
    assign low_count     = low_items_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        res.load      = 1'b0;
        res.status    = status_reg;
        res.front_sel = front_sel_reg;
        res.back_sel  = back_sel_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_LOAD: begin
                res.load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            high_head_reg  <= '0;
            high_tail_reg  <= '0;
            low_head_reg   <= '0;
            low_tail_reg   <= '0;
            high_items_reg <= '0;
            low_items_reg  <= '0;
        end else begin
            state_reg      <= state_next;
            high_head_reg  <= high_head_next;
            high_tail_reg  <= high_tail_next;
            low_head_reg   <= low_head_next;
            low_tail_reg   <= low_tail_next;
            high_items_reg <= high_items_next;
            low_items_reg  <= low_items_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= status_next;
            front_sel_reg <= front_sel_next;
            back_sel_reg  <= back_sel_next;
        end
    end

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((CNT_W + 1)'(high_items_reg) + (CNT_W + 1)'(low_items_reg)) <= (CNT_W + 1)'(CAPACITY))
        else $error("queue occupancy exceeds capacity");

    a_high_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (high_items_reg == '0) |-> (high_head_reg == high_tail_reg))
        else $error("high ring pointers disagree with empty count");

    a_low_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (low_items_reg == '0) |-> (low_head_reg == low_tail_reg))
        else $error("low ring pointers disagree with empty count");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_op == OP_PUSH) && (total != CNT_FULL)) |=>
        ((CNT_W + 1)'(high_items_reg) + (CNT_W + 1)'(low_items_reg))
            == (CNT_W + 1)'($past(total)) + 1'b1)
        else $error("accepted push did not add one item");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.load && (status_reg == STAT_POP_EMPTY)) |->
        ((high_items_reg == '0) && (low_items_reg == '0)))
        else $error("pop-on-empty status with items queued");

endmodule
